// ----- rtl/cke_pkg.sv -----
// ----------------------------------------------------------------------------
// cke_pkg
// Shared types, constants and helper functions of the canonical k-mer
// extender.
// ----------------------------------------------------------------------------
package cke_pkg;

    localparam int LAYERS      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [5:0] KMER_LENGTH_RESET = 6'd28;
    localparam logic [3:0] TREE_PREFIX_RESET = 4'd4;

    localparam logic REG_KMER_LENGTH = 1'b0;
    localparam logic REG_TREE_PREFIX = 1'b1;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam logic [1:0] ORIENT_REVERSE    = 2'd0;
    localparam logic [1:0] ORIENT_FORWARD    = 2'd1;
    localparam logic [1:0] ORIENT_UNASSIGNED = 2'd2;

    localparam logic [1:0] LAST_LAYER = 2'(LAYERS - 1);

    localparam logic [63:0] INITIAL_COUNT = 64'd1;

    typedef struct packed {
        logic       func;
        logic [7:0] symbol;
    } cke_in_t;

    typedef struct packed {
        logic [1:0]  layer;
        logic [15:0] tree_index;
        logic [63:0] entry_word;
    } cke_out_t;

    typedef struct packed {
        logic       flush;
        logic [1:0] code;
    } cke_op_t;

    typedef struct packed {
        logic [1:0]  layer;
        logic        adjust;
        logic [63:0] src;
    } cke_req_t;

    function automatic logic [63:0] shr64(input logic [63:0] v, input logic signed [9:0] n);
        logic [63:0] r;
        if (n < 10'sd0 || n > 10'sd63) begin
            r = 64'd0;
        end else begin
            r = v >> n[5:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] shl64(input logic [63:0] v, input logic signed [9:0] n);
        logic [63:0] r;
        if (n < 10'sd0 || n > 10'sd63) begin
            r = 64'd0;
        end else begin
            r = v << n[5:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/cke_front.sv -----
// ----------------------------------------------------------------------------
// cke_front
// Classifies each accepted item as a base code or as a flush.
// ----------------------------------------------------------------------------
module cke_front import cke_pkg::*; (
    input  logic    s_valid,
    output logic    s_ready,
    input  cke_in_t s_item,
    output logic    op_valid,
    input  logic    op_ready,
    output cke_op_t op
);

    always_comb begin
        op.flush = 1'b0;
        op.code  = BASE_A;
        if (s_item.func) begin
            op.flush = 1'b1;
        end else begin
            case (s_item.symbol) inside
                "A", "a": op.code = BASE_A;
                "C", "c": op.code = BASE_C;
                "G", "g": op.code = BASE_G;
                "T", "t": op.code = BASE_T;
                default:  op.flush = 1'b1;
            endcase
        end
    end

    assign op_valid = s_valid;
    assign s_ready  = op_ready;

endmodule

// ----- rtl/cke_queue.sv -----
// ----------------------------------------------------------------------------
// cke_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module cke_queue import cke_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cke_op_t in_op,
    output logic    out_valid,
    input  logic    out_ready,
    output cke_op_t out_op
);

    cke_op_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W:0]     count_reg;
    logic                     push;
    logic                     pop;

    assign in_ready  = count_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/cke_back.sv -----
// ----------------------------------------------------------------------------
// cke_back
// Keeps the read state, grows extensions and raises tree entry requests.
// ----------------------------------------------------------------------------
module cke_back import cke_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [5:0] kmer_length,
    input  logic       op_valid,
    output logic       op_ready,
    input  cke_op_t    op,
    output logic       req_valid,
    input  logic       req_ready,
    output cke_req_t   req
);

    logic [63:0] fw_reg, fw_next;
    logic [63:0] rw_reg, rw_next;
    logic [6:0]  pos_reg, pos_next;
    logic [5:0]  seen_reg, seen_next;
    logic [1:0]  ext_reg, ext_next;
    logic [1:0]  orient_reg, orient_next;
    logic        req_valid_reg, req_valid_next;
    cke_req_t    req_reg, req_next;

    logic        fire;
    logic        emit;
    logic [5:0]  seen_inc;
    logic [63:0] fw_new;
    logic [63:0] rw_new;
    logic [63:0] kmask;
    logic [6:0]  kshift;
    logic        b;
    logic        same;
    logic        grow;
    logic        last;
    logic [1:0]  layer;
    logic [5:0]  kpos;

    assign op_ready  = !req_valid_reg || req_ready;
    assign fire      = op_valid && op_ready;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    always_comb begin
        kshift = 7'd64 - {kmer_length, 1'b0};
        if (kmer_length == 6'd0 || kmer_length > 6'd32) begin
            kmask = 64'd0;
        end else begin
            kmask = ~64'd0 >> kshift[5:0];
        end
    end

    always_comb begin
        fw_next        = fw_reg;
        rw_next        = rw_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        ext_next       = ext_reg;
        orient_next    = orient_reg;
        req_next       = req_reg;
        emit           = 1'b0;
        seen_inc       = (seen_reg < kmer_length) ? seen_reg + 6'd1 : seen_reg;
        fw_new         = {fw_reg[61:0], op.code};
        rw_new         = rw_reg | (pos_reg[6] ? 64'd0 : ({62'd0, ~op.code} << pos_reg[5:0]));
        b              = (fw_new & kmask) < ((rw_new >> {ext_reg, 1'b0}) & kmask);
        same           = (b && orient_reg == ORIENT_FORWARD) ||
                         (!b && orient_reg == ORIENT_REVERSE);
        grow           = orient_reg[1] || (ext_reg < LAST_LAYER && same);
        layer          = ext_reg + {1'b0, same} - 2'd1;
        last           = layer == LAST_LAYER;
        kpos           = kmer_length - {5'd0, last};

        if (fire) begin
            if (op.flush) begin
                if (ext_reg != 2'd0) begin
                    emit          = 1'b1;
                    req_next.layer  = ext_reg - 2'd1;
                    req_next.adjust = 1'b0;
                    req_next.src    = (orient_reg == ORIENT_FORWARD) ? fw_reg : rw_reg;
                end
                fw_next     = 64'd0;
                rw_next     = 64'd0;
                pos_next    = 7'd0;
                seen_next   = 6'd0;
                ext_next    = 2'd0;
                orient_next = ORIENT_UNASSIGNED;
            end else begin
                seen_next = seen_inc;
                fw_next   = fw_new;
                rw_next   = rw_new;
                pos_next  = pos_reg + 7'd2;
                if (seen_inc >= kmer_length) begin
                    if (grow) begin
                        ext_next    = ext_reg + 2'd1;
                        orient_next = b ? ORIENT_FORWARD : ORIENT_REVERSE;
                    end else begin
                        emit            = 1'b1;
                        req_next.layer  = layer;
                        req_next.adjust = (orient_reg == ORIENT_FORWARD) && !same;
                        req_next.src    = (orient_reg == ORIENT_FORWARD) ? fw_new : rw_new;
                        fw_next         = fw_new & kmask;
                        rw_next         = (rw_new >> ({1'b0, layer} + 3'd1) * 4'd2) & kmask;
                        ext_next        = last ? 2'd0 : 2'd1;
                        pos_next        = {kpos, 1'b0};
                        orient_next     = {last, b};
                    end
                end
            end
        end

        if (fire) begin
            req_valid_next = emit;
        end else if (req_ready) begin
            req_valid_next = 1'b0;
        end else begin
            req_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg        <= 64'd0;
            rw_reg        <= 64'd0;
            pos_reg       <= 7'd0;
            seen_reg      <= 6'd0;
            ext_reg       <= 2'd0;
            orient_reg    <= ORIENT_UNASSIGNED;
            req_valid_reg <= 1'b0;
        end else begin
            fw_reg        <= fw_next;
            rw_reg        <= rw_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            ext_reg       <= ext_next;
            orient_reg    <= orient_next;
            req_valid_reg <= req_valid_next;
        end
    end

    // An unassigned orientation always comes with no pending extension.
    assert property (@(posedge aclk) disable iff (!aresetn)
        orient_reg[1] |-> ext_reg == 2'd0)
        else $error("pending extension without an assigned orientation");

    // A flush leaves the read state cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && op.flush) |=> (fw_reg == 64'd0 && rw_reg == 64'd0 && ext_reg == 2'd0 &&
                                seen_reg == 6'd0 && orient_reg == ORIENT_UNASSIGNED))
        else $error("read state not cleared after flush");

    // The reverse word position always stays on a base boundary.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> pos_reg[0] == 1'b0)
        else $error("reverse position off a base boundary");

endmodule

// ----- rtl/cke_format.sv -----
// ----------------------------------------------------------------------------
// cke_format
// Aligns a tree entry request into tree index and entry word and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module cke_format import cke_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [5:0] kmer_length,
    input  logic [3:0] tree_prefix_bases,
    input  logic       req_valid,
    output logic       req_ready,
    input  cke_req_t   req,
    output logic       m_valid,
    input  logic       m_ready,
    output cke_out_t   m_result
);

    logic            m_valid_reg, m_valid_next;
    cke_out_t        result_reg;
    cke_out_t        result_next;
    logic signed [9:0] k_s;
    logic signed [9:0] l_s;
    logic signed [9:0] p_s;
    logic signed [9:0] rs;
    logic signed [9:0] ls_base;
    logic signed [9:0] ls;
    logic [63:0]     mer_mask;
    logic [63:0]     prefix_mask;
    logic [63:0]     ti;
    logic            load;

    assign req_ready = !m_valid_reg || m_ready;
    assign load      = req_valid && req_ready;
    assign m_valid   = m_valid_reg;
    assign m_result  = result_reg;

    always_comb begin
        k_s     = signed'({4'd0, kmer_length});
        l_s     = signed'({8'd0, req.layer});
        p_s     = signed'({6'd0, tree_prefix_bases});
        rs      = (k_s + l_s - p_s) * 10'sd2 + (req.adjust ? 10'sd2 : 10'sd0);
        ls_base = (10'sd32 - k_s - l_s + p_s) * 10'sd2;
        ls      = ls_base - (req.adjust ? 10'sd2 : 10'sd0);
        if (!req.adjust || ls_base <= 10'sd0) begin
            mer_mask = ~64'd0;
        end else if (ls_base >= 10'sd64) begin
            mer_mask = 64'd0;
        end else begin
            mer_mask = ~((64'd1 << ls_base[5:0]) - 64'd1);
        end
        prefix_mask            = (64'd1 << {tree_prefix_bases, 1'b0}) - 64'd1;
        ti                     = shr64(req.src, rs) & prefix_mask;
        result_next.layer      = req.layer;
        result_next.tree_index = ti[15:0];
        result_next.entry_word = (shl64(req.src, ls) & mer_mask) | INITIAL_COUNT;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/canonical_kmer_extender_core.sv -----
// ----------------------------------------------------------------------------
// canonical_kmer_extender_core
// Streaming canonical k-mer extractor over 2-bit DNA codes with (k+x)-mer
// extension and tree entry formatting.
// ----------------------------------------------------------------------------
// The core takes one read character or end-of-read item per clock cycle and
// sustains that rate indefinitely while the result side keeps up. The rate is
// set by the read-state update in the back end, which handles one base per
// cycle. A tree entry reaches the result channel by these steps after the
// transfer that causes it: the item is classified and written into the queue
// at the transfer itself, the read state is updated in the back end, and the
// entry is aligned into the output register.
// The queue and the output register let each side stall on its own.
// Write kmer_length (address 0) and tree_prefix_bases (address 4) only while
// no transfer is in flight. No clearing pass is needed after reset.
module canonical_kmer_extender_core import cke_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  cke_in_t     s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output cke_out_t    m_result
);

    logic [5:0] kmer_length_reg;
    logic [3:0] tree_prefix_reg;
    logic       cfg_write;

    logic       fe_valid;
    logic       fe_ready;
    cke_op_t    fe_op;
    logic       q_valid;
    logic       q_ready;
    cke_op_t    q_op;
    logic       req_valid;
    logic       req_ready;
    cke_req_t   req;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= KMER_LENGTH_RESET;
            tree_prefix_reg <= TREE_PREFIX_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_KMER_LENGTH: kmer_length_reg <= pwdata[5:0];
                REG_TREE_PREFIX: tree_prefix_reg <= pwdata[3:0];
                default:         kmer_length_reg <= kmer_length_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_KMER_LENGTH: prdata = {26'd0, kmer_length_reg};
            REG_TREE_PREFIX: prdata = {28'd0, tree_prefix_reg};
            default:         prdata = 32'd0;
        endcase
    end

    cke_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .op_valid (fe_valid),
        .op_ready (fe_ready),
        .op       (fe_op)
    );

    cke_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_op     (fe_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    cke_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .kmer_length (kmer_length_reg),
        .op_valid    (q_valid),
        .op_ready    (q_ready),
        .op          (q_op),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req)
    );

    cke_format u_format (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .kmer_length       (kmer_length_reg),
        .tree_prefix_bases (tree_prefix_reg),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .req               (req),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result          (m_result)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the canonical k-mer extender core. A tracker class
// follows the read state of the core for every accepted input transfer and
// queues the tree entries it should produce. Each result transfer is compared
// field by field with the oldest queued entry. The run covers several
// register settings, including out-of-range ones, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module testbench import cke_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 13;
    localparam int SETTLE_WAIT = 8;

    class tree_entry_tracker;
        logic [5:0]  mer_bases;
        logic [3:0]  prefix_bases;
        logic [63:0] fwd_word;
        logic [63:0] rev_word;
        logic [6:0]  rev_pos;
        logic [5:0]  bases_seen;
        logic [1:0]  ext_layer;
        logic [1:0]  prev_orient;
        cke_out_t    awaited[$];
        int          mismatches;

        function new();
            mer_bases    = KMER_LENGTH_RESET;
            prefix_bases = TREE_PREFIX_RESET;
            mismatches   = 0;
            clear_read();
        endfunction

        function void clear_read();
            fwd_word    = '0;
            rev_word    = '0;
            rev_pos     = '0;
            bases_seen  = '0;
            ext_layer   = '0;
            prev_orient = ORIENT_UNASSIGNED;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_KMER_LENGTH) begin
                mer_bases = value[5:0];
            end else begin
                prefix_bases = value[3:0];
            end
        endfunction

        function bit decode(logic [7:0] sym, output logic [1:0] code);
            decode = 1'b1;
            code   = BASE_A;
            case (sym)
                "A", "a": code = BASE_A;
                "C", "c": code = BASE_C;
                "G", "g": code = BASE_G;
                "T", "t": code = BASE_T;
                default: decode = 1'b0;
            endcase
        endfunction

        function logic [63:0] lsh(logic [63:0] v, longint n);
            return (n < 0 || n > 63) ? 64'd0 : (v << n);
        endfunction

        function logic [63:0] rsh(logic [63:0] v, longint n);
            return (n < 0 || n > 63) ? 64'd0 : (v >> n);
        endfunction

        function logic [63:0] kmer_mask();
            longint kl;
            kl = mer_bases;
            return rsh(~64'd0, (32 - kl) * 2);
        endfunction

        function longint right_amt(longint lay);
            longint kl, pb;
            kl = mer_bases;
            pb = prefix_bases;
            return (kl + lay - pb) * 2;
        endfunction

        function longint left_amt(longint lay);
            longint kl, pb;
            kl = mer_bases;
            pb = prefix_bases;
            return (32 - kl - lay + pb) * 2;
        endfunction

        function logic [63:0] mer_keep(longint lay);
            longint kl, pb, m;
            logic [63:0] count_bits;
            kl = mer_bases;
            pb = prefix_bases;
            m  = (32 - kl + pb - lay) * 2;
            if (m <= 0) begin
                count_bits = 64'd0;
            end else if (m >= 64) begin
                count_bits = ~64'd0;
            end else begin
                count_bits = (64'd1 << m) - 64'd1;
            end
            return ~count_bits;
        endfunction

        function logic [15:0] index_of(logic [63:0] v, longint n);
            longint pb;
            logic [63:0] tree_bits;
            pb = prefix_bases;
            tree_bits = lsh(64'd1, 2 * pb) - 64'd1;
            return 16'(rsh(v, n) & tree_bits);
        endfunction

        function void queue_entry(longint lay, logic [15:0] ti, logic [63:0] word);
            cke_out_t e;
            e.layer      = lay[1:0];
            e.tree_index = ti;
            e.entry_word = word;
            awaited.insert(awaited.size(), e);
        endfunction

        function void flush_read();
            longint lay;
            logic [63:0] src;
            if (ext_layer != 2'd0) begin
                lay = ext_layer - 1;
                src = (prev_orient == ORIENT_FORWARD) ? fwd_word : rev_word;
                queue_entry(lay, index_of(src, right_amt(lay)),
                            lsh(src, left_amt(lay)) | INITIAL_COUNT);
            end
            clear_read();
        endfunction

        function void absorb_item(cke_in_t it);
            logic [1:0]  code;
            logic [1:0]  comp;
            logic [63:0] km;
            logic [63:0] word;
            logic [15:0] ti;
            longint      lay, kl;
            bit          b, same, grow, last;
            if (it.func) begin
                flush_read();
                return;
            end
            if (!decode(it.symbol, code)) begin
                flush_read();
                return;
            end
            if (bases_seen < mer_bases) begin
                bases_seen = bases_seen + 6'd1;
            end
            comp     = BASE_T - code;
            fwd_word = {fwd_word[61:0], code};
            rev_word = rev_word | lsh({62'd0, comp}, rev_pos);
            rev_pos  = rev_pos + 7'd2;
            if (bases_seen < mer_bases) begin
                return;
            end
            km   = kmer_mask();
            b    = (fwd_word & km) < (rsh(rev_word, 2 * ext_layer) & km);
            same = (b && prev_orient == ORIENT_FORWARD) ||
                   (!b && prev_orient == ORIENT_REVERSE);
            grow = (prev_orient > ORIENT_FORWARD) || (ext_layer < LAST_LAYER && same);
            if (grow) begin
                ext_layer   = ext_layer + 2'd1;
                prev_orient = b ? ORIENT_FORWARD : ORIENT_REVERSE;
                return;
            end
            lay = (longint'(ext_layer) + (same ? 1 : 0) - 1) & 3;
            if (prev_orient != ORIENT_FORWARD) begin
                ti   = index_of(rev_word, right_amt(lay));
                word = lsh(rev_word, left_amt(lay)) | INITIAL_COUNT;
            end else if (same) begin
                ti   = index_of(fwd_word, right_amt(lay));
                word = lsh(fwd_word, left_amt(lay)) | INITIAL_COUNT;
            end else begin
                ti   = index_of(fwd_word, right_amt(lay) + 2);
                word = (lsh(fwd_word, left_amt(lay) - 2) & mer_keep(lay)) | INITIAL_COUNT;
            end
            queue_entry(lay, ti, word);
            fwd_word  = fwd_word & km;
            rev_word  = rsh(rev_word, (lay + 1) * 2) & km;
            last      = (lay == LAYERS - 1);
            ext_layer = last ? 2'd0 : 2'd1;
            kl        = mer_bases;
            rev_pos   = 7'((kl - (last ? 1 : 0)) * 2);
            if (last) begin
                prev_orient = ORIENT_UNASSIGNED | {1'b0, b};
            end else begin
                prev_orient = b ? ORIENT_FORWARD : ORIENT_REVERSE;
            end
        endfunction

        function void compare_entry(cke_out_t got);
            cke_out_t want;
            if (awaited.size() == 0) begin
                $error("unexpected tree entry: layer %0d tree_index %0h entry_word %h",
                       got.layer, got.tree_index, got.entry_word);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.layer !== want.layer) begin
                $error("layer: expected %0d, got %0d", want.layer, got.layer);
                mismatches++;
            end
            if (got.tree_index !== want.tree_index) begin
                $error("tree_index: expected %0h, got %0h", want.tree_index, got.tree_index);
                mismatches++;
            end
            if (got.entry_word !== want.entry_word) begin
                $error("entry_word: expected %h, got %h", want.entry_word, got.entry_word);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    cke_in_t     s_item  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    cke_out_t    m_result;

    tree_entry_tracker tracker = new();
    int unsigned       cycle_count = 0;
    bit                send_calm = 1'b0;

    int phase_kmer[PHASES]   = '{10, 32, 28, 10, 63, 0, 20, 33, 16, 12, 31, -1, -1};
    int phase_prefix[PHASES] = '{1, 8, 4, 15, 15, 0, 3, 2, 8, 0, 5, -1, -1};

    canonical_kmer_extender_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic cke_in_t mk(logic f, logic [7:0] sym);
        cke_in_t r;
        r.func   = f;
        r.symbol = sym;
        return r;
    endfunction

    function automatic logic [7:0] letter(logic [1:0] code, bit lower);
        logic [7:0] ch;
        case (code)
            BASE_A:  ch = "A";
            BASE_C:  ch = "C";
            BASE_G:  ch = "G";
            default: ch = "T";
        endcase
        return lower ? (ch | 8'h20) : ch;
    endfunction

    task automatic push_item(cke_in_t it);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.absorb_item(it);
    endtask

    task automatic reg_write(logic idx, logic [31:0] value);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        tracker.set_register(idx, value);
        want = (idx == REG_KMER_LENGTH) ? {26'd0, value[5:0]} : {28'd0, value[3:0]};
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            $error("register %0d readback: expected %0d, got %0d", idx, want, prdata);
            tracker.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic feed_reads(int budget);
        int         sent, len, shape, ending;
        logic [1:0] pair_a, pair_b, code;
        logic [7:0] sym;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(mk(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
                sent++;
            end else begin
                len    = $urandom_range(1, int'(tracker.mer_bases) + 40);
                shape  = $urandom_range(0, 3);
                pair_a = 2'($urandom_range(0, 3));
                pair_b = 2'($urandom_range(0, 3));
                repeat (len) begin
                    case (shape)
                        0:       code = 2'($urandom_range(0, 1));
                        1:       code = $urandom_range(0, 1) ? pair_a : pair_b;
                        default: code = 2'($urandom_range(0, 3));
                    endcase
                    push_item(mk(1'b0, letter(code, 1'($urandom_range(0, 1)))));
                end
                sent += len;
                ending = $urandom_range(0, 2);
                if (ending == 0) begin
                    push_item(mk(1'b1, 8'($urandom_range(0, 255))));
                    sent++;
                end else if (ending == 1) begin
                    do begin
                        sym = 8'($urandom_range(0, 255));
                    end while (tracker.decode(sym, code));
                    push_item(mk(1'b0, sym));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int    gap;
        bit    calm;
        calm = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            tracker.compare_entry(m_result);
        end
    end

    initial begin
        string letters;
        int    ph, i, k_now, p_now;
        letters = "AaCcGgTt";
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (ph = 0; ph < PHASES; ph++) begin
            k_now = (phase_kmer[ph] < 0) ? $urandom_range(10, 32) : phase_kmer[ph];
            p_now = (phase_prefix[ph] < 0) ? $urandom_range(1, 8) : phase_prefix[ph];
            reg_write(REG_KMER_LENGTH, ($urandom() & ~32'h3F) | k_now);
            reg_write(REG_TREE_PREFIX, ($urandom() & ~32'hF) | p_now);
            if (ph == 0) begin
                push_item(mk(1'b1, 8'hFF));
                push_item(mk(1'b0, 8'h00));
                for (i = 0; i < letters.len(); i++) begin
                    push_item(mk(1'b0, letters[i]));
                end
                repeat (4) push_item(mk(1'b0, "A"));
                push_item(mk(1'b0, 8'h80));
                repeat (10) push_item(mk(1'b0, "t"));
                push_item(mk(1'b1, 8'h00));
            end
            feed_reads(k_now > 32 ? 200 : 100);
            settle();
        end
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
